>>> sv/hmec_pkg.sv
// Package: shared types, constants and state codes for the hit merge block.
`timescale 1ns / 1ps
package hmec_pkg;

   localparam int MaxHits = 255;
   localparam int CountWidth = 9;
   localparam int SumWidth = 37;
   localparam int WsumWidth = 61;
   localparam int QuotWidth = 61;
   localparam int DivCountWidth = 6;

   localparam logic [1:0] KIND_BANK = 2'd0;
   localparam logic [1:0] KIND_COLLISION = 2'd1;
   localparam logic [1:0] KIND_TERMINATION = 2'd2;
   localparam logic [1:0] KIND_OTHER = 2'd3;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_ZERO_TOTAL = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN_KIND = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   localparam logic CSR_DETECTOR_CELL = 1'b0;
   localparam logic CSR_PAIR_REACTION = 1'b1;

   localparam logic signed [10:0] PAIR_REACTION_RESET = -11'sd4;
   localparam logic [23:0] DETECTOR_CELL_RESET = 24'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic update;
      logic div_start;
      logic div_step;
      logic div_next_axis;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic       result_needed;
      logic       need_divide;
      logic       div_done;
      logic       last_axis;
   } stat_type;

endpackage

>>> sv/hmec_if.sv
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps
interface hmec_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [31:0]        history_number;
   logic [27:0]        energy;
   logic [19:0]        nuclide_id;
   logic [23:0]        cell_req;
   logic signed [10:0] reaction;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [23:0] pos_z;
   logic [47:0]        event_time;
   logic [31:0]        weight;
   modport source (output valid, kind, history_number, energy, nuclide_id, cell_req,
      reaction, pos_x, pos_y, pos_z, event_time, weight, input ready);
   modport sink (input valid, kind, history_number, energy, nuclide_id, cell_req,
      reaction, pos_x, pos_y, pos_z, event_time, weight, output ready);
endinterface

interface hmec_rsp_if;
   logic               valid;
   logic               ready;
   logic [31:0]        out_history;
   logic [19:0]        out_nuclide;
   logic signed [23:0] out_x;
   logic signed [23:0] out_y;
   logic signed [23:0] out_z;
   logic signed [10:0] out_reaction;
   logic signed [36:0] deposited;
   logic [47:0]        out_time;
   logic [31:0]        out_weight;
   logic [1:0]         status;
   modport source (output valid, out_history, out_nuclide, out_x, out_y, out_z,
      out_reaction, deposited, out_time, out_weight, status, input ready);
   modport sink (input valid, out_history, out_nuclide, out_x, out_y, out_z,
      out_reaction, deposited, out_time, out_weight, status, output ready);
endinterface

interface hmec_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> sv/hmec_ctrl.sv
// Controller: sequences accumulate, divide and emit for each request.
`timescale 1ns / 1ps
module hmec_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  hmec_pkg::stat_type stat,
   output hmec_pkg::cmd_type  cmd
);
   import hmec_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            if (stat.result_needed && stat.need_divide) begin
               state_in = ST_DIV_START;
            end else if (stat.result_needed) begin
               cmd.load_result = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) begin
               if (stat.last_axis) begin
                  cmd.load_result = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  cmd.div_next_axis = 1'b1;
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

>>> sv/hmec_divider.sv
// Divider: signed restoring division, two quotient bits a cycle while step is high, truncating.
`timescale 1ns / 1ps
module hmec_divider (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic                                     step,
   input  logic signed [hmec_pkg::WsumWidth-1:0]    dividend,
   input  logic signed [hmec_pkg::SumWidth-1:0]     divisor,
   output logic                                     done,
   output logic signed [23:0]                       quotient
);
   import hmec_pkg::*;

   localparam int Steps = QuotWidth / 2 + 1;
   localparam logic [DivCountWidth-1:0] LastStep = DivCountWidth'(Steps - 1);

   logic [QuotWidth-1:0]     rem_ff, rem_in;
   logic [QuotWidth-1:0]     quo_ff, quo_in;
   logic [SumWidth-1:0]      den_ff, den_in;
   logic                     neg_ff, neg_in;
   logic [DivCountWidth-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;

   logic [QuotWidth-1:0] num_mag;
   logic [SumWidth-1:0]  den_mag;
   logic [QuotWidth:0]   trial;
   logic [QuotWidth:0]   rem_sh;
   logic [QuotWidth-1:0] quo_sh;
   logic [QuotWidth:0]   rem2;
   logic [QuotWidth-1:0] quo2;
   logic signed [QuotWidth:0] q_signed;

   always_comb begin
      num_mag = dividend[WsumWidth-1] ? QuotWidth'(-dividend) : QuotWidth'(dividend);
      den_mag = divisor[SumWidth-1] ? SumWidth'(-divisor) : SumWidth'(divisor);
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      rem_sh = '0;
      quo_sh = '0;
      rem2 = '0;
      quo2 = '0;
      trial = '0;
      if (start) begin
         rem_in = '0;
         quo_in = num_mag;
         den_in = den_mag;
         neg_in = dividend[WsumWidth-1] ^ divisor[SumWidth-1];
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (step && busy_ff) begin
         // two quotient bits a cycle
         rem_sh = {rem_ff, quo_ff[QuotWidth-1]};
         quo_sh = {quo_ff[QuotWidth-2:0], 1'b0};
         trial = rem_sh - {{(QuotWidth + 1 - SumWidth){1'b0}}, den_ff};
         if (!trial[QuotWidth]) begin
            rem_sh = trial;
            quo_sh[0] = 1'b1;
         end
         rem2 = {rem_sh[QuotWidth-1:0], quo_sh[QuotWidth-1]};
         quo2 = {quo_sh[QuotWidth-2:0], 1'b0};
         trial = rem2 - {{(QuotWidth + 1 - SumWidth){1'b0}}, den_ff};
         if (!trial[QuotWidth]) begin
            rem2 = trial;
            quo2[0] = 1'b1;
         end
         if (cnt_ff == LastStep) begin
            // odd width: last step takes one bit only
            rem_in = rem_sh[QuotWidth-1:0];
            quo_in = quo_sh;
            busy_in = 1'b0;
         end else begin
            rem_in = rem2[QuotWidth-1:0];
            quo_in = quo2;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = !busy_ff;

   always_comb begin
      q_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (den_ff == '0) begin
         quotient = '0;
      end else if (q_signed > $signed((QuotWidth + 1)'(8388607))) begin
         quotient = 24'sd8388607;
      end else if (q_signed < -$signed((QuotWidth + 1)'(8388608))) begin
         quotient = -24'sd8388608;
      end else begin
         quotient = q_signed[23:0];
      end
   end
endmodule

>>> sv/hmec_datapath.sv
// Datapath: event state, running sums, centroid divider and result register.
`timescale 1ns / 1ps
module hmec_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   hmec_req_if.sink            req,
   hmec_csr_if.sink            csr,
   input  hmec_pkg::cmd_type   cmd,
   output hmec_pkg::stat_type  stat,
   hmec_rsp_if.source          rsp
);
   import hmec_pkg::*;

   logic [23:0]          detector_cell_ff;
   logic signed [10:0]   pair_code_ff;
   logic [1:0]           kind_ff;
   logic [31:0]          hist_ff;
   logic [27:0]          energy_ff;
   logic [19:0]          nuc_ff;
   logic [23:0]          cell_ff;
   logic signed [10:0]   reac_ff;
   logic signed [23:0]   pos_ff [3];
   logic [47:0]          time_ff;
   logic [31:0]          weight_ff;

   logic [27:0]          prev_energy_ff;
   logic [19:0]          bank_nuc_ff;
   logic [CountWidth-1:0] hit_count_ff;
   logic                 overflow_ff;
   logic signed [SumWidth-1:0]  esum_ff;
   logic signed [WsumWidth-1:0] wsum_ff [3];

   logic [31:0]          f_hist_ff;
   logic [19:0]          f_nuc_ff;
   logic signed [10:0]   f_reac_ff;
   logic signed [23:0]   f_pos_ff [3];
   logic [47:0]          f_time_ff;
   logic [31:0]          f_weight_ff;

   logic [1:0]           axis_ff;
   logic signed [23:0]   cent_ff [3];

   logic [31:0]          o_hist_ff;
   logic [19:0]          o_nuc_ff;
   logic signed [23:0]   o_pos_ff [3];
   logic signed [10:0]   o_reac_ff;
   logic signed [SumWidth-1:0] o_dep_ff;
   logic [47:0]          o_time_ff;
   logic [31:0]          o_weight_ff;
   logic [1:0]           o_status_ff;

   logic                 hit;
   logic                 pair;
   logic [27:0]          cur;
   logic signed [28:0]   dep;
   logic signed [52:0]   prod [3];
   logic                 div_done;
   logic signed [23:0]   quotient;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         detector_cell_ff <= DETECTOR_CELL_RESET;
         pair_code_ff <= PAIR_REACTION_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_DETECTOR_CELL: detector_cell_ff <= csr.data;
            CSR_PAIR_REACTION: pair_code_ff <= csr.data[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req.kind;
         hist_ff <= req.history_number;
         energy_ff <= req.energy;
         nuc_ff <= req.nuclide_id;
         cell_ff <= req.cell_req;
         reac_ff <= req.reaction;
         pos_ff[0] <= req.pos_x;
         pos_ff[1] <= req.pos_y;
         pos_ff[2] <= req.pos_z;
         time_ff <= req.event_time;
         weight_ff <= req.weight;
      end
   end

   assign hit = (kind_ff == KIND_COLLISION) && (cell_ff == detector_cell_ff);
   assign pair = reac_ff == pair_code_ff;
   assign cur = (hit && pair) ? '0 : energy_ff;
   assign dep = $signed({1'b0, prev_energy_ff}) - $signed({1'b0, cur});

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod[a] = dep * pos_ff[a];
      end
   end

   assign stat.result_needed = (kind_ff == KIND_OTHER) ||
      ((kind_ff == KIND_TERMINATION) && (hit_count_ff != '0));
   assign stat.need_divide = (kind_ff == KIND_TERMINATION) && (hit_count_ff > 9'd1);
   assign stat.div_done = div_done;
   assign stat.last_axis = axis_ff == 2'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_energy_ff <= '0;
         bank_nuc_ff <= '0;
         hit_count_ff <= '0;
         overflow_ff <= 1'b0;
         esum_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            wsum_ff[a] <= '0;
         end
      end else if (cmd.update) begin
         case (kind_ff)
            KIND_BANK: begin
               bank_nuc_ff <= nuc_ff;
               hit_count_ff <= '0;
               overflow_ff <= 1'b0;
               esum_ff <= '0;
               for (int a = 0; a < 3; a++) begin
                  wsum_ff[a] <= '0;
               end
               prev_energy_ff <= energy_ff;
            end
            KIND_COLLISION: begin
               prev_energy_ff <= cur;
               if (hit) begin
                  if (hit_count_ff < CountWidth'(MaxHits)) begin
                     esum_ff <= esum_ff + SumWidth'(dep);
                     for (int a = 0; a < 3; a++) begin
                        wsum_ff[a] <= wsum_ff[a] + WsumWidth'(prod[a]);
                     end
                     hit_count_ff <= hit_count_ff + 1'b1;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
               end
            end
            KIND_TERMINATION: prev_energy_ff <= energy_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && hit && (hit_count_ff == '0)) begin
         f_hist_ff <= hist_ff;
         f_nuc_ff <= bank_nuc_ff;
         f_reac_ff <= reac_ff;
         f_pos_ff <= pos_ff;
         f_time_ff <= time_ff;
         f_weight_ff <= weight_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= '0;
      end else if (cmd.update) begin
         axis_ff <= '0;
      end else if (cmd.div_next_axis) begin
         axis_ff <= axis_ff + 1'b1;
      end
      if (cmd.div_step && div_done) begin
         cent_ff[axis_ff] <= quotient;
      end
   end

   hmec_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (wsum_ff[axis_ff]),
      .divisor  (esum_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         if (kind_ff == KIND_OTHER) begin
            o_hist_ff <= '0;
            o_nuc_ff <= '0;
            o_reac_ff <= '0;
            o_dep_ff <= '0;
            o_time_ff <= '0;
            o_weight_ff <= '0;
            for (int a = 0; a < 3; a++) begin
               o_pos_ff[a] <= '0;
            end
            o_status_ff <= STATUS_UNKNOWN_KIND;
         end else begin
            o_hist_ff <= f_hist_ff;
            o_nuc_ff <= f_nuc_ff;
            o_reac_ff <= f_reac_ff;
            o_dep_ff <= esum_ff;
            o_time_ff <= f_time_ff;
            o_weight_ff <= f_weight_ff;
            if (hit_count_ff == 9'd1) begin
               o_pos_ff <= f_pos_ff;
            end else begin
               o_pos_ff[0] <= cent_ff[0];
               o_pos_ff[1] <= cent_ff[1];
               o_pos_ff[2] <= quotient;
            end
            if (overflow_ff) begin
               o_status_ff <= STATUS_OVERFLOW;
            end else if ((hit_count_ff != 9'd1) && (esum_ff == '0)) begin
               o_status_ff <= STATUS_ZERO_TOTAL;
            end else begin
               o_status_ff <= STATUS_OK;
            end
         end
      end
   end

   assign rsp.out_history = o_hist_ff;
   assign rsp.out_nuclide = o_nuc_ff;
   assign rsp.out_x = o_pos_ff[0];
   assign rsp.out_y = o_pos_ff[1];
   assign rsp.out_z = o_pos_ff[2];
   assign rsp.out_reaction = o_reac_ff;
   assign rsp.deposited = o_dep_ff;
   assign rsp.out_time = o_time_ff;
   assign rsp.out_weight = o_weight_ff;
   assign rsp.status = o_status_ff;
endmodule

>>> sv/hit_merge_energy_centroid.sv
// Top level: hit merging with energy-weighted centroid.
`timescale 1ns / 1ps
//  channel | direction | handshake        | payload
//  req     | in        | valid / ready    | one track event
//  rsp     | out       | valid / ready    | one merged hit
//  csr     | in        | valid / ready    | register index and data
//
//  A bank, collision or non-emitting termination passes through the update
//  state and back to idle; unknown kinds and single-hit terminations also
//  pass through emit and wait there for rsp.ready. A multi-hit termination
//  runs the shared divider three times, once for each axis, before emit.
//  Reset clears all control state and the sums; the csr registers take their reset values.
//  A stalled result holds the block: no request is taken until it leaves.
module hit_merge_energy_centroid (
   input logic        clock,
   input logic        reset,
   hmec_req_if.sink   req,
   hmec_rsp_if.source rsp,
   hmec_csr_if.sink   csr
);
   import hmec_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller owns the req and rsp handshakes, datapath owns all payload and csr.ready
   hmec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hmec_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .accept (req.valid && req.ready),
      .req    (req),
      .csr    (csr),
      .cmd    (cmd),
      .stat   (stat),
      .rsp    (rsp)
   );
endmodule
